// ===== rtl/core/ppcl_pkg.sv =====
// shared constants, register map and types of the pi pwm current loop
package ppcl_pkg;

    // converter and gain formats
    localparam int ADC_BITS       = 10;
    localparam int GAIN_FRAC_BITS = 8;

    // field widths
    localparam int GAIN_W   = 16;
    localparam int LEVEL_W  = 10;
    localparam int WAVE_W   = 16;
    localparam int TOP_W    = 16;
    localparam int DEC_W    = 8;
    localparam int POINTS_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DUTY_W   = 16;
    localparam int ERR_W    = ADC_BITS + 1;
    localparam int INTEG_W  = 32;

    // percent arithmetic in q(GAIN_FRAC_BITS)
    localparam int PERCENT_FULL = 100;
    localparam int FULL_SCALE   = PERCENT_FULL << GAIN_FRAC_BITS;
    localparam int HALF_SCALE   = 50 << GAIN_FRAC_BITS;
    localparam int P_W          = $clog2(FULL_SCALE + 1);

    // shared multiplier and accumulator
    localparam int MUL_A_W = INTEG_W + 1;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = GAIN_W + INTEG_W + 2;

    // divide by 100 after dropping the fraction bits: reciprocal multiply
    localparam int Q_W         = P_W + TOP_W - GAIN_FRAC_BITS;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam longint RECIP_M = (longint'(1) << RECIP_SHIFT) / PERCENT_FULL;
    localparam int QHAT_W      = Q_W + RECIP_W - RECIP_SHIFT;
    localparam int REM_W       = Q_W + 1;

    // queue between front and back
    localparam int QDEPTH = 2;

    // reset values of the settings
    localparam logic [GAIN_W-1:0]   KP_RESET     = 16'd0;
    localparam logic [GAIN_W-1:0]   KI_RESET     = 16'd0;
    localparam logic [LEVEL_W-1:0]  REF_HI_RESET = 10'd800;
    localparam logic [LEVEL_W-1:0]  REF_LO_RESET = 10'd200;
    localparam logic [WAVE_W-1:0]   WAVE_RESET   = 16'd1000;
    localparam logic [TOP_W-1:0]    TOP_RESET    = 16'd2399;
    localparam logic [DEC_W-1:0]    DEC_RESET    = 8'd10;
    localparam logic [POINTS_W-1:0] POINTS_RESET = 10'd200;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN        = 3'd0,
        REG_KI_GAIN        = 3'd1,
        REG_REF_HIGH       = 3'd2,
        REG_REF_LOW        = 3'd3,
        REG_WAVE_LENGTH    = 3'd4,
        REG_PWM_TOP        = 3'd5,
        REG_DECIMATION     = 3'd6,
        REG_CAPTURE_POINTS = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic [LEVEL_W-1:0]       ref_high;
        logic [LEVEL_W-1:0]       ref_low;
        logic [WAVE_W-1:0]        wave_length;
        logic [TOP_W-1:0]         pwm_top;
        logic [DEC_W-1:0]         decimation;
        logic [POINTS_W-1:0]      capture_points;
    } cfg_t;

    // one classified tick waiting for the control law
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic                      cap_valid;
        logic [ADC_BITS-1:0]       cap_adc;
        logic [LEVEL_W-1:0]        cap_ref;
        logic                      cap_last;
    } entry_t;

endpackage

// ===== rtl/core/ppcl_if.sv =====
// channel interfaces: tick input, result output and settings write
interface ppcl_tick_if import ppcl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;
    logic                start_capture;

    modport source (output valid, adc_sample, start_capture, input ready);
    modport sink   (input valid, adc_sample, start_capture, output ready);
endinterface

interface ppcl_result_if import ppcl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   duty_value;
    logic                capture_valid;
    logic [ADC_BITS-1:0] capture_adc;
    logic [LEVEL_W-1:0]  capture_ref;
    logic                capture_last;

    modport source (output valid, duty_value, capture_valid, capture_adc, capture_ref,
                    capture_last, input ready);
    modport sink   (input valid, duty_value, capture_valid, capture_adc, capture_ref,
                    capture_last, output ready);
endinterface

interface ppcl_cfg_if import ppcl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pi_pwm_current_loop.sv =====
// top level: pi current loop with clamped pwm duty and decimated capture
// a tick transfer reaches its result through the queue, then 8 sequencer steps
// the back end starts a tick only once the last has left its shared multiplier sequence
// the front end and the two-entry queue take up to 2 further ticks while the back end is busy
// reset: rst_n clears the loop state, the queue and the output, and loads default settings
module pi_pwm_current_loop import ppcl_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    ppcl_cfg_if.sink       cfg,
    ppcl_tick_if.sink      tick,
    ppcl_result_if.source  result
);

    // settings register file
    cfg_t   regs_reg;

    // front to queue
    logic   push;
    entry_t wr_entry;
    logic   full;

    // queue to back
    logic   pop;
    entry_t rd_entry;
    logic   empty;

    // settings writes are always taken; the host must write only while the loop is quiet, the block does not enforce it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kp_gain        <= KP_RESET;
            regs_reg.ki_gain        <= KI_RESET;
            regs_reg.ref_high       <= REF_HI_RESET;
            regs_reg.ref_low        <= REF_LO_RESET;
            regs_reg.wave_length    <= WAVE_RESET;
            regs_reg.pwm_top        <= TOP_RESET;
            regs_reg.decimation     <= DEC_RESET;
            regs_reg.capture_points <= POINTS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            // each transfer writes one register, keeping only its low bits
            unique case (cfg_reg_t'(cfg.index))
                REG_KP_GAIN:        regs_reg.kp_gain        <= cfg.data[GAIN_W-1:0];
                REG_KI_GAIN:        regs_reg.ki_gain        <= cfg.data[GAIN_W-1:0];
                REG_REF_HIGH:       regs_reg.ref_high       <= cfg.data[LEVEL_W-1:0];
                REG_REF_LOW:        regs_reg.ref_low        <= cfg.data[LEVEL_W-1:0];
                REG_WAVE_LENGTH:    regs_reg.wave_length    <= cfg.data[WAVE_W-1:0];
                REG_PWM_TOP:        regs_reg.pwm_top        <= cfg.data[TOP_W-1:0];
                REG_DECIMATION:     regs_reg.decimation     <= cfg.data[DEC_W-1:0];
                REG_CAPTURE_POINTS: regs_reg.capture_points <= cfg.data[POINTS_W-1:0];
                default:            regs_reg                <= regs_reg;
            endcase
        end
    end

    // front end: all per-tick state (wave position, integrator, capture counters)
    // advances in the cycle of the tick transfer, so the back end never feeds back
    ppcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs_reg),
        .tick     (tick),
        .full     (full),
        .push     (push),
        .wr_entry (wr_entry)
    );

    // short queue lets the front keep taking ticks while the back end computes
    ppcl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .rd_entry (rd_entry),
        .empty    (empty)
    );

    // back end: kp*err + ki*integral, 50 percent offset, clamp, then
    // duty = floor(p * pwm_top / (100 << frac)) via reciprocal multiply and one correction
    ppcl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs_reg),
        .empty    (empty),
        .rd_entry (rd_entry),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== rtl/core/ppcl_front.sv =====
// front end: reference wave, error, saturating integrator and capture bookkeeping
module ppcl_front import ppcl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       regs,
    ppcl_tick_if.sink  tick,
    input  logic       full,
    output logic       push,
    output entry_t     wr_entry
);

    logic [WAVE_W-1:0]         wave_reg,  wave_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic                      armed_reg, armed_next;
    logic [DEC_W-1:0]          dec_reg,   dec_next;
    logic [POINTS_W-1:0]       cnt_reg,   cnt_next;

    logic [LEVEL_W-1:0]        ref_val;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ_base;
    logic [INTEG_W:0]          integ_sum;
    logic                      armed_base;
    logic                      cap_valid;
    logic                      cap_last;
    logic [WAVE_W-1:0]         wave_inc;

    assign tick.ready = !full;
    assign push       = tick.valid && tick.ready;

    always_comb
    begin
        // start flag clears the integrator and restarts capture
        integ_base = tick.start_capture ? '0 : integ_reg;
        armed_base = tick.start_capture || armed_reg;
        dec_next   = tick.start_capture ? '0 : dec_reg;
        cnt_next   = tick.start_capture ? '0 : cnt_reg;

        ref_val = (wave_reg < (regs.wave_length >> 1)) ? regs.ref_high : regs.ref_low;
        err     = ERR_W'({1'b0, ref_val}) - ERR_W'({1'b0, tick.adc_sample});

        integ_sum = {integ_base[INTEG_W-1], integ_base}
                  + {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        cap_valid  = 1'b0;
        cap_last   = 1'b0;
        armed_next = armed_base;
        if (armed_base)
        begin
            dec_next = dec_next + 1'b1;
            if (dec_next == regs.decimation)
            begin
                dec_next  = '0;
                cap_valid = 1'b1;
                cnt_next  = cnt_next + 1'b1;
            end
            if (cnt_next >= regs.capture_points)
            begin
                cnt_next   = '0;
                armed_next = 1'b0;
                cap_last   = 1'b1;
            end
        end

        wave_inc  = wave_reg + 1'b1;
        wave_next = (wave_inc >= regs.wave_length) ? '0 : wave_inc;

        wr_entry.err       = err;
        wr_entry.integ     = integ_next;
        wr_entry.cap_valid = cap_valid;
        wr_entry.cap_adc   = cap_valid ? tick.adc_sample : '0;
        wr_entry.cap_ref   = cap_valid ? ref_val : '0;
        wr_entry.cap_last  = cap_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg  <= '0;
            integ_reg <= '0;
            armed_reg <= 1'b0;
            dec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (push)
        begin
            wave_reg  <= wave_next;
            integ_reg <= integ_next;
            armed_reg <= armed_next;
            dec_reg   <= dec_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ppcl_queue.sv =====
// two-entry queue between the front end and the control law sequencer
module ppcl_queue import ppcl_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_entry,
    output logic   full,
    input  logic   pop,
    output entry_t rd_entry,
    output logic   empty
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ppcl_back.sv =====
// back end: pi law, clamp and duty scaling on one shared multiplier
module ppcl_back import ppcl_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           regs,
    input  logic           empty,
    input  entry_t         rd_entry,
    output logic           pop,
    ppcl_result_if.source  result
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL_P = 8'b0000_0010,
        ST_MUL_I = 8'b0000_0100,
        ST_SUM   = 8'b0000_1000,
        ST_CLAMP = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_RECIP = 8'b0100_0000,
        ST_FIX   = 8'b1000_0000
    } back_state_t;

    back_state_t state_reg, state_next;

    entry_t                    ent_reg;
    logic [MUL_P_W-1:0]        prod_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [P_W-1:0]            p_reg;
    logic [Q_W-1:0]            q_reg;

    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      cap_valid_reg;
    logic [ADC_BITS-1:0]       cap_adc_reg;
    logic [LEVEL_W-1:0]        cap_ref_reg;
    logic                      cap_last_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      load_out;
    logic [QHAT_W-1:0]         qhat;
    logic [REM_W-1:0]          fix_rem;
    logic [DUTY_W-1:0]         duty_next;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL_P)
        begin
            mul_a = {{(MUL_A_W-ERR_W){ent_reg.err[ERR_W-1]}}, ent_reg.err};
            mul_b = {{(MUL_B_W-GAIN_W){regs.kp_gain[GAIN_W-1]}}, regs.kp_gain};
        end
        else if (state_reg == ST_MUL_I)
        begin
            mul_a = {ent_reg.integ[INTEG_W-1], ent_reg.integ};
            mul_b = {{(MUL_B_W-GAIN_W){regs.ki_gain[GAIN_W-1]}}, regs.ki_gain};
        end
        else if (state_reg == ST_SCALE)
        begin
            mul_a = {{(MUL_A_W-P_W){1'b0}}, p_reg};
            mul_b = {{(MUL_B_W-TOP_W){1'b0}}, regs.pwm_top};
        end
        else if (state_reg == ST_RECIP)
        begin
            mul_a = {{(MUL_A_W-Q_W){1'b0}}, prod_reg[P_W+TOP_W-1:GAIN_FRAC_BITS]};
            mul_b = {{(MUL_B_W-RECIP_W){1'b0}}, RECIP_W'(RECIP_M)};
        end
        mul_p = mul_a * mul_b;
    end

    // quotient estimate is exact or one short
    assign qhat      = prod_reg[RECIP_SHIFT+QHAT_W-1:RECIP_SHIFT];
    assign fix_rem   = {1'b0, q_reg} - REM_W'(qhat) * REM_W'(PERCENT_FULL);
    assign duty_next = (fix_rem >= REM_W'(PERCENT_FULL)) ? DUTY_W'(qhat + 1'b1)
                                                         : DUTY_W'(qhat);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_FIX;
            ST_FIX:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= rd_entry;
        end
        if (state_reg == ST_MUL_P || state_reg == ST_SCALE)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_I)
        begin
            acc_reg  <= prod_reg[ACC_W-1:0];
            prod_reg <= mul_p;
        end
        if (state_reg == ST_SUM)
        begin
            acc_reg <= acc_reg + prod_reg[ACC_W-1:0] + ACC_W'(HALF_SCALE);
        end
        if (state_reg == ST_CLAMP)
        begin
            if (acc_reg[ACC_W-1])
            begin
                p_reg <= '0;
            end
            else if (acc_reg > ACC_W'(FULL_SCALE))
            begin
                p_reg <= P_W'(FULL_SCALE);
            end
            else
            begin
                p_reg <= acc_reg[P_W-1:0];
            end
        end
        if (state_reg == ST_RECIP)
        begin
            q_reg    <= prod_reg[P_W+TOP_W-1:GAIN_FRAC_BITS];
            prod_reg <= mul_p;
        end
        if (load_out)
        begin
            duty_reg      <= duty_next;
            cap_valid_reg <= ent_reg.cap_valid;
            cap_adc_reg   <= ent_reg.cap_adc;
            cap_ref_reg   <= ent_reg.cap_ref;
            cap_last_reg  <= ent_reg.cap_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.duty_value    = duty_reg;
    assign result.capture_valid = cap_valid_reg;
    assign result.capture_adc   = cap_adc_reg;
    assign result.capture_ref   = cap_ref_reg;
    assign result.capture_last  = cap_last_reg;

    // clamped percent never exceeds full scale
    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCALE |-> p_reg <= P_W'(FULL_SCALE))
        else $error("clamped percent above full scale");

    // reciprocal estimate is at most one below the true quotient
    a_recip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIX |-> fix_rem < REM_W'(2 * PERCENT_FULL))
        else $error("reciprocal quotient off by more than one");

    // a finished result waits while the output register is still occupied
    a_fix_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIX && out_valid_reg && !result.ready |=> state_reg == ST_FIX)
        else $error("result left the sequencer while output was busy");

endmodule

// ===== dv/ppcl_duty_checker.sv =====
// checker for the pi pwm current loop: watches all channels, predicts each tick, compares results
module ppcl_duty_checker import ppcl_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    ppcl_cfg_if    cfg,
    ppcl_tick_if   tick,
    ppcl_result_if result,
    output int     mismatch_count,
    output int     results_due
);

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic                cap_valid;
        logic [ADC_BITS-1:0] cap_adc;
        logic [LEVEL_W-1:0]  cap_ref;
        logic                cap_last;
    } tick_out_t;

    // settings copy
    shortint               kp_q8;
    shortint               ki_q8;
    logic [LEVEL_W-1:0]    level_high;
    logic [LEVEL_W-1:0]    level_low;
    logic [WAVE_W-1:0]     wave_len;
    logic [TOP_W-1:0]      duty_top;
    logic [DEC_W-1:0]      decim;
    logic [POINTS_W-1:0]   points;

    // loop state copy
    logic [WAVE_W-1:0]     wave_pos;
    longint                integ;
    logic                  armed;
    logic [DEC_W-1:0]      dec_cnt;
    logic [POINTS_W-1:0]   cap_cnt;

    tick_out_t             tick_results_due [$];
    int                    results_seen;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
    endtask

    // one control tick: pi law, clamp, duty scaling and capture sequencing
    function automatic tick_out_t run_control_tick(input logic [ADC_BITS-1:0] adc,
                                                   input logic start);
        tick_out_t          r;
        logic [LEVEL_W-1:0] level;
        longint             err;
        longint             u;
        longint             p;
        r = '0;
        if (start)
        begin
            integ   = 0;
            armed   = 1'b1;
            dec_cnt = '0;
            cap_cnt = '0;
        end
        level = (wave_pos < (wave_len >> 1)) ? level_high : level_low;
        err   = longint'(level) - longint'(adc);
        integ = integ + err;
        if (integ > INTEG_MAX)
            integ = INTEG_MAX;
        if (integ < INTEG_MIN)
            integ = INTEG_MIN;
        u = longint'(kp_q8) * err + longint'(ki_q8) * integ;
        p = u + HALF_SCALE;
        if (p > FULL_SCALE)
            p = FULL_SCALE;
        else if (p < 0)
            p = 0;
        r.duty = DUTY_W'((p * longint'(duty_top)) / FULL_SCALE);
        if (armed)
        begin
            dec_cnt = dec_cnt + 8'd1;
            if (dec_cnt == decim)
            begin
                dec_cnt     = '0;
                r.cap_valid = 1'b1;
                r.cap_adc   = adc;
                r.cap_ref   = level;
                cap_cnt     = cap_cnt + 10'd1;
            end
            if (cap_cnt >= points)
            begin
                cap_cnt    = '0;
                armed      = 1'b0;
                r.cap_last = 1'b1;
            end
        end
        wave_pos = wave_pos + 16'd1;
        if (wave_pos >= wave_len)
            wave_pos = '0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        tick_out_t want;
        if (!rst_n)
        begin
            kp_q8          = shortint'(KP_RESET);
            ki_q8          = shortint'(KI_RESET);
            level_high     = REF_HI_RESET;
            level_low      = REF_LO_RESET;
            wave_len       = WAVE_RESET;
            duty_top       = TOP_RESET;
            decim          = DEC_RESET;
            points         = POINTS_RESET;
            wave_pos       = '0;
            integ          = 0;
            armed          = 1'b0;
            dec_cnt        = '0;
            cap_cnt        = '0;
            mismatch_count = 0;
            results_seen   = 0;
            tick_results_due.delete();
            results_due   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_KP_GAIN:        kp_q8      = shortint'(cfg.data);
                    REG_KI_GAIN:        ki_q8      = shortint'(cfg.data);
                    REG_REF_HIGH:       level_high = cfg.data[LEVEL_W-1:0];
                    REG_REF_LOW:        level_low  = cfg.data[LEVEL_W-1:0];
                    REG_WAVE_LENGTH:    wave_len   = cfg.data[WAVE_W-1:0];
                    REG_PWM_TOP:        duty_top   = cfg.data[TOP_W-1:0];
                    REG_DECIMATION:     decim      = cfg.data[DEC_W-1:0];
                    REG_CAPTURE_POINTS: points     = cfg.data[POINTS_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (tick_results_due.size() == 0)
                    report_mismatch("result with no tick waiting");
                else
                begin
                    want = tick_results_due.pop_front();
                    check_field("duty_value", result.duty_value, want.duty);
                    check_field("capture_valid", result.capture_valid, want.cap_valid);
                    check_field("capture_adc", result.capture_adc, want.cap_adc);
                    check_field("capture_ref", result.capture_ref, want.cap_ref);
                    check_field("capture_last", result.capture_last, want.cap_last);
                end
                results_seen++;
            end
            if (tick.valid && tick.ready)
                tick_results_due.push_back(run_control_tick(tick.adc_sample, tick.start_capture));
            results_due <= tick_results_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// top of the pi pwm current loop testbench: clock, reset, stimulus, receiver stalls and verdict
module testbench;
    import ppcl_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_CYCLES     = 400;
    // settling wait after the last result has come out
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int ADC_MAX         = (1 << ADC_BITS) - 1;
    localparam logic [ADC_BITS-1:0] ADC_TOP  = '1;
    localparam logic [ADC_BITS-1:0] ADC_ZERO = '0;

    logic clk;
    logic rst_n;

    ppcl_cfg_if    cfg_bus ();
    ppcl_tick_if   tick_bus ();
    ppcl_result_if result_bus ();

    int   mismatch_count;
    int   results_due;
    int   cycle_count;
    cfg_t active_settings;

    // idle control: the sender's share is used only by the stimulus process,
    // the receiver's share and the hold-off request are read by the ready process
    int   send_idle_pct;
    int   stall_pct;
    logic hold_req;

    pi_pwm_current_loop i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .tick   (tick_bus),
        .result (result_bus)
    );

    ppcl_duty_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_bus),
        .tick           (tick_bus),
        .result         (result_bus),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run guard: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off counted here so the block backs up
    initial
    begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_seen)
                hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one settings write; valid stays high so back-to-back writes need no gap
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
    endtask

    // write every register, then drop valid once
    task automatic apply_settings(input cfg_t s);
        write_register(REG_KP_GAIN, s.kp_gain);
        write_register(REG_KI_GAIN, s.ki_gain);
        write_register(REG_REF_HIGH, s.ref_high);
        write_register(REG_REF_LOW, s.ref_low);
        write_register(REG_WAVE_LENGTH, s.wave_length);
        write_register(REG_PWM_TOP, s.pwm_top);
        write_register(REG_DECIMATION, s.decimation);
        write_register(REG_CAPTURE_POINTS, s.capture_points);
        cfg_bus.valid <= 1'b0;
        active_settings = s;
    endtask

    // offer one tick after a random gap; returns at the edge where it transferred
    task automatic send_tick(input logic [ADC_BITS-1:0] adc, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tick_bus.valid         <= 1'b1;
        tick_bus.adc_sample    <= adc;
        tick_bus.start_capture <= start;
        @(posedge clk);
        while (!tick_bus.ready) @(posedge clk);
    endtask

    // stop offering, let every result come out, then let the pipe settle
    task automatic drain_block();
        tick_bus.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic cfg_t make_settings(input int kp, input int ki, input int hi,
                                           input int lo, input int wave, input int top,
                                           input int dec, input int pts);
        cfg_t s;
        s.kp_gain        = GAIN_W'(kp);
        s.ki_gain        = GAIN_W'(ki);
        s.ref_high       = LEVEL_W'(hi);
        s.ref_low        = LEVEL_W'(lo);
        s.wave_length    = WAVE_W'(wave);
        s.pwm_top        = TOP_W'(top);
        s.decimation     = DEC_W'(dec);
        s.capture_points = POINTS_W'(pts);
        return s;
    endfunction

    // mostly small gains so duty lands between the clamps, sometimes the extremes
    function automatic int pick_gain();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(128)) - 64;
        endcase
    endfunction

    function automatic int pick_level();
        case ($urandom_range(5))
            0:       return 0;
            1:       return ADC_MAX;
            default: return int'($urandom_range(ADC_MAX));
        endcase
    endfunction

    // short waves and short capture runs so both halves and whole runs show up
    function automatic cfg_t random_settings();
        int wave;
        int top;
        int dec;
        int pts;
        case ($urandom_range(9))
            0:       wave = 2;
            1:       wave = 65535;
            2:       wave = int'($urandom_range(1));
            3:       wave = int'($urandom_range(65535));
            default: wave = int'($urandom_range(60, 2));
        endcase
        case ($urandom_range(5))
            0:       top = 1;
            1:       top = 65535;
            default: top = int'($urandom_range(65535, 1));
        endcase
        case ($urandom_range(11))
            0:       dec = 0;
            1:       dec = 255;
            2:       dec = int'($urandom_range(255, 1));
            default: dec = int'($urandom_range(6, 1));
        endcase
        case ($urandom_range(11))
            0:       pts = 0;
            1:       pts = 1023;
            2:       pts = 1;
            default: pts = int'($urandom_range(30, 1));
        endcase
        return make_settings(pick_gain(), pick_gain(), pick_level(), pick_level(),
                             wave, top, dec, pts);
    endfunction

    initial
    begin
        logic [ADC_BITS-1:0] adc;
        int                  level;
        // every input known from time zero
        rst_n                  = 1'b0;
        hold_req               = 1'b0;
        send_idle_pct          = 0;
        stall_pct              = 0;
        tick_bus.valid         = 1'b0;
        tick_bus.adc_sample    = '0;
        tick_bus.start_capture = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = REG_KP_GAIN;
        cfg_bus.data           = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale reference swing, unity kp, three-point runs with a re-arm mid run
        apply_settings(make_settings(256, 4, ADC_MAX, 0, 4, 65535, 1, 3));
        send_tick(ADC_TOP, 1'b1);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_TOP, 1'b1);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_TOP, 1'b0);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_TOP, 1'b0);
        drain_block();

        // most negative kp, largest ki, zero wave length, wrapping decimation,
        // zero run length so the first armed tick ends the run
        apply_settings(make_settings(-32768, 32767, 0, ADC_MAX, 0, 1, 0, 0));
        send_tick(ADC_ZERO, 1'b1);
        send_tick(ADC_TOP, 1'b0);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_TOP, 1'b1);
        drain_block();

        // opposite gain extremes, wave length one, largest decimation setting, longest run
        apply_settings(make_settings(32767, -32768, 512, 511, 1, 2399, 255, 1023));
        send_tick(ADC_ZERO, 1'b1);
        send_tick(ADC_TOP, 1'b0);
        send_tick(10'd512, 1'b0);
        send_tick(10'd511, 1'b0);
        drain_block();

        // pure integral action, longest wave, one-point run captured on the second tick
        apply_settings(make_settings(0, 1, 700, 300, 65535, 1000, 2, 1));
        send_tick(10'd700, 1'b1);
        send_tick(10'd300, 1'b0);
        send_tick(ADC_ZERO, 1'b0);
        send_tick(ADC_TOP, 1'b0);
        send_tick(10'd700, 1'b0);
        drain_block();

        // random phases, each with fresh settings and its own idle pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 77;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 77;
                end
                default:
                begin
                    send_idle_pct = 20;
                    stall_pct    <= 20;
                end
            endcase
            apply_settings(random_settings());
            // the long hold-off starts with this phase while ticks keep coming
            if (ph == PRESSURE_PHASE)
            begin
                send_idle_pct = 0;
                hold_req     <= 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(3))
                    0:       adc = ADC_BITS'($urandom);
                    1:       adc = $urandom_range(1) ? ADC_TOP : ADC_ZERO;
                    default:
                    begin
                        // near the reference so the loop sits between the clamps
                        level = $urandom_range(1) ? int'(active_settings.ref_high)
                                                  : int'(active_settings.ref_low);
                        level = level + int'($urandom_range(40)) - 20;
                        if (level < 0)
                            level = 0;
                        else if (level > ADC_MAX)
                            level = ADC_MAX;
                        adc = ADC_BITS'(level);
                    end
                endcase
                // occasional start: well-formed capture runs with re-arms now and then
                send_tick(adc, $urandom_range(99) < 3);
            end
            if (ph == PRESSURE_PHASE)
                hold_req <= 1'b0;
            drain_block();
        end

        if (mismatch_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== pi_pwm_current_loop.f =====
rtl/core/ppcl_pkg.sv
rtl/core/ppcl_if.sv
rtl/core/ppcl_front.sv
rtl/core/ppcl_queue.sv
rtl/core/ppcl_back.sv
rtl/core/pi_pwm_current_loop.sv
dv/ppcl_duty_checker.sv
dv/testbench.sv
